@@ design/rpn_pkg.sv @@
// ----------------------------------------------------------------------------
// RPN calculator package
// Command and status codes, Q32.32 limits and saturating helpers.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int unsigned NumVars = 26;

  typedef enum logic [3:0] {
    FUNC_PUSH   = 4'd0,
    FUNC_ADD    = 4'd1,
    FUNC_SUB    = 4'd2,
    FUNC_MUL    = 4'd3,
    FUNC_DIV    = 4'd4,
    FUNC_REM    = 4'd5,
    FUNC_TOP    = 4'd6,
    FUNC_DUP    = 4'd7,
    FUNC_SWAP   = 4'd8,
    FUNC_CLEAR  = 4'd9,
    FUNC_ASSIGN = 4'd10,
    FUNC_RECALL = 4'd11,
    FUNC_LAST   = 4'd12,
    FUNC_EOL    = 4'd13
  } func_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_ZERO_DIV = 3'd3,
    ST_FEW_SWAP = 3'd4,
    ST_BAD_VAR  = 3'd5
  } status_e;

  localparam logic [63:0] QMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] QMin = 64'h8000_0000_0000_0000;

  // Clamp an unsigned magnitude (with overflow flag) to a signed result
  function automatic logic [63:0] sat_signed(input logic neg, input logic hi,
                                             input logic [63:0] lo);
    logic [63:0] lim;
    lim = neg ? QMin : QMax;
    if (hi || (lo > lim)) return lim;
    return neg ? (64'd0 - lo) : lo;
  endfunction

  function automatic logic [63:0] q_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) return a[63] ? QMin : QMax;
    return s;
  endfunction

  function automatic logic [63:0] q_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a - b;
    if ((a[63] != b[63]) && (s[63] != a[63])) return a[63] ? QMin : QMax;
    return s;
  endfunction

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

@@ design/rpn_if.sv @@
// ----------------------------------------------------------------------------
// RPN calculator channels
// Command channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rpn_cmd_if;
  logic        valid;
  logic        ready;
  logic [3:0]  func;
  logic signed [63:0] operand_value;
  logic [4:0]  var_index;

  modport source (output valid, func, operand_value, var_index, input ready);
  modport sink   (input valid, func, operand_value, var_index, output ready);
endinterface

interface rpn_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        show_valid;
  logic signed [63:0] shown_value;
  logic [7:0]  depth_now;

  modport source (output valid, status, show_valid, shown_value, depth_now,
                  input ready);
  modport sink   (input valid, status, show_valid, shown_value, depth_now,
                  output ready);
endinterface

@@ design/rpn_stack_calculator_unit.sv @@
// ----------------------------------------------------------------------------
// RPN stack calculator
// Executes one tokenized reverse-Polish command per word on a Q32.32 stack.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  cmd_i   | in  | func, operand_value, var_index
//  res_o   | out | status, show_valid, shown_value, depth_now
//
// One command at a time; cmd_i.ready is high only while idle.
// Push/top/dup/recall/last/clear/eol finish at dispatch; assign, add/sub, swap,
// mul (four 32x32 partial products on one multiplier), div and rem (one restoring
// divide step per cycle) pass through further states, plus result wait.
// Reset clears count, variables and history; stack entries are undefined.
// The result word holds until taken; the next command waits for it.
module rpn_stack_calculator_unit import rpn_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  rpn_cmd_if.sink   cmd_i,
  rpn_res_if.source res_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_WAIT = 4'd2,
                         S_POPA = 4'd3, S_MUL  = 4'd4, S_DIV  = 4'd5,
                         S_SWRD = 4'd6, S_SWP1 = 4'd7, S_SWP2 = 4'd8,
                         S_PUSH = 4'd9, S_OUT  = 4'd10;

  logic [3:0]  state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [3:0]  op_q;
  logic [63:0] val_q;
  logic [4:0]  vidx_q;
  logic [63:0] a_q, a_d, b_q, b_d;
  logic        empty_q, empty_d, neg_q, neg_d;
  logic [2:0]  status_q, status_d;
  logic        show_q, show_d;
  logic [63:0] shown_q, shown_d, last_q, last_d;
  logic [4:0]  letter_q, letter_d;
  logic        prev_rec_q, prev_rec_d;
  logic [127:0] acc_q, acc_d;
  logic [63:0] prod_q, prod_d;
  logic [95:0] num_q, num_d, quo_q, quo_d;
  logic [63:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [6:0]  step_q, step_d;

  logic [63:0] stack_mem [STACK_DEPTH];
  logic [63:0] rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic        we;
  logic [63:0] wd;

  logic [63:0] vars_q [NumVars];
  logic        var_we;
  logic [63:0] var_wd;

  logic        cnt_zero, cnt_full;
  logic [31:0] mul_x, mul_y;
  logic [64:0] dstep;
  logic        dge;
  logic [63:0] a_pop, ma, mb, t_res;

  assign cnt_zero = (count_q == '0);
  assign cnt_full = (count_q >= CW'(STACK_DEPTH));

  // Stack memory: one write port, one registered read port
  assign rd_addr = (state_q == S_SWRD) ? AW'(count_q - CW'(2)) : AW'(count_q - CW'(1));
  always_ff @(posedge clk_i) begin
    if (we) stack_mem[wr_addr] <= wd;
    rd_q <= stack_mem[rd_addr];
  end

  // Shared multiplier operand select
  always_comb begin
    unique case (step_q[1:0])
      2'd0: begin mul_x = a_q[31:0];  mul_y = b_q[31:0];  end
      2'd1: begin mul_x = a_q[31:0];  mul_y = b_q[63:32]; end
      2'd2: begin mul_x = a_q[63:32]; mul_y = b_q[31:0];  end
      default: begin mul_x = a_q[63:32]; mul_y = b_q[63:32]; end
    endcase
  end

  // Shared restoring divide step
  assign dstep = {rem_q, num_q[95]};
  assign dge   = (dstep >= {1'b0, dvs_q});

  // Second operand as popped; zero when the stack is empty
  assign a_pop = cnt_zero ? 64'd0 : rd_q;
  assign ma = mag(a_pop);
  assign mb = mag(b_q);

  // Final result of a binary operation
  always_comb begin
    case (op_q)
      FUNC_ADD: t_res = q_add(a_q, b_q);
      FUNC_SUB: t_res = q_sub(a_q, b_q);
      FUNC_MUL: t_res = sat_signed(neg_q, |acc_q[127:96], acc_q[95:32]);
      FUNC_DIV: t_res = sat_signed(neg_q, |quo_q[95:64], quo_q[63:0]);
      default:  t_res = neg_q ? (64'd0 - rem_q) : rem_q;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;   count_d = count_q;  a_d = a_q;       b_d = b_q;
    empty_d = empty_q;   neg_d = neg_q;      status_d = status_q;
    show_d = show_q;     shown_d = shown_q;  last_d = last_q;
    letter_d = letter_q; prev_rec_d = prev_rec_q;
    acc_d = acc_q;       prod_d = prod_q;    num_d = num_q;   quo_d = quo_q;
    rem_d = rem_q;       dvs_d = dvs_q;      step_d = step_q;
    we = 1'b0;  wr_addr = AW'(count_q);  wd = rd_q;
    var_we = 1'b0;  var_wd = a_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) state_d = S_DISP;
      end
      S_DISP: begin
        status_d = ST_OK;  show_d = 1'b0;  shown_d = '0;  empty_d = 1'b0;
        state_d = S_OUT;
        prev_rec_d = (op_q == FUNC_RECALL) && (vidx_q < 5'(NumVars));
        case (op_q)
          FUNC_PUSH, FUNC_RECALL, FUNC_LAST: begin
            wd = (op_q == FUNC_PUSH) ? val_q :
                 (op_q == FUNC_LAST) ? last_q : vars_q[vidx_q];
            if (op_q == FUNC_RECALL && vidx_q >= 5'(NumVars)) begin
              status_d = ST_BAD_VAR;
            end else begin
              if (op_q == FUNC_RECALL) letter_d = vidx_q;
              if (cnt_full) status_d = ST_FULL;
              else begin we = 1'b1; count_d = count_q + CW'(1); end
            end
          end
          FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV, FUNC_REM, FUNC_ASSIGN,
          FUNC_EOL: begin
            b_d = cnt_zero ? 64'd0 : rd_q;
            empty_d = cnt_zero;
            if (!cnt_zero) count_d = count_q - CW'(1);
            state_d = S_WAIT;
            if (op_q == FUNC_EOL) begin
              if (cnt_zero) status_d = ST_EMPTY;
              show_d = 1'b1;  shown_d = b_d;  last_d = b_d;  state_d = S_OUT;
            end else if ((op_q == FUNC_DIV || op_q == FUNC_REM) && b_d == 64'd0) begin
              status_d = cnt_zero ? ST_EMPTY : ST_ZERO_DIV;
              state_d = S_OUT;
            end else if (op_q == FUNC_ASSIGN &&
                         (!prev_rec_q || letter_q >= 5'(NumVars))) begin
              status_d = ST_BAD_VAR;
              state_d = S_OUT;
            end
          end
          FUNC_TOP: begin
            if (cnt_zero) status_d = ST_EMPTY;
            show_d = 1'b1;
            shown_d = cnt_zero ? 64'd0 : rd_q;
            last_d = shown_d;
          end
          FUNC_DUP: begin
            if (cnt_zero) status_d = ST_EMPTY;
            else if (cnt_full) status_d = ST_FULL;
            else begin we = 1'b1; count_d = count_q + CW'(1); end
          end
          FUNC_SWAP: begin
            if (count_q < CW'(2)) status_d = ST_FEW_SWAP;
            else begin b_d = rd_q; state_d = S_SWRD; end
          end
          FUNC_CLEAR: count_d = '0;
          default: ;
        endcase
      end
      S_WAIT: state_d = S_POPA;
      S_POPA: begin
        a_d = a_pop;
        empty_d = empty_q | cnt_zero;
        if (!cnt_zero) count_d = count_q - CW'(1);
        acc_d = '0;  step_d = '0;  rem_d = '0;  quo_d = '0;
        case (op_q)
          FUNC_ASSIGN: begin
            var_we = 1'b1;  var_wd = a_pop;
            if (empty_d) status_d = ST_EMPTY;
            state_d = S_OUT;
          end
          FUNC_MUL: begin
            neg_d = a_pop[63] ^ b_q[63];
            a_d = ma;  b_d = mb;
            state_d = S_MUL;
          end
          FUNC_DIV, FUNC_REM: begin
            neg_d = (op_q == FUNC_DIV) ? (a_pop[63] ^ b_q[63]) : a_pop[63];
            dvs_d = mb;
            num_d = {ma, 32'd0};
            step_d = (op_q == FUNC_DIV) ? 7'd96 : 7'd64;
            state_d = S_DIV;
          end
          default: state_d = S_PUSH;
        endcase
      end
      S_MUL: begin
        prod_d = 64'(mul_x) * 64'(mul_y);
        if (step_q != '0) begin
          case (step_q[2:0])
            3'd1:    acc_d = acc_q + 128'(prod_q);
            3'd4:    acc_d = acc_q + {prod_q, 64'd0};
            default: acc_d = acc_q + {32'd0, prod_q, 32'd0};
          endcase
        end
        step_d = step_q + 7'd1;
        if (step_q == 7'd4) state_d = S_PUSH;
      end
      S_DIV: begin
        rem_d = dge ? 64'(dstep - {1'b0, dvs_q}) : dstep[63:0];
        quo_d = {quo_q[94:0], dge};
        num_d = {num_q[94:0], 1'b0};
        step_d = step_q - 7'd1;
        if (step_q == 7'd1) state_d = S_PUSH;
      end
      S_SWRD: state_d = S_SWP1;
      S_SWP1: begin
        we = 1'b1;  wr_addr = AW'(count_q - CW'(1));  wd = rd_q;
        state_d = S_SWP2;
      end
      S_SWP2: begin
        we = 1'b1;  wr_addr = AW'(count_q - CW'(2));  wd = b_q;
        state_d = S_OUT;
      end
      S_PUSH: begin
        wd = t_res;
        if (!cnt_full) begin we = 1'b1; count_d = count_q + CW'(1); end
        if (empty_q) status_d = ST_EMPTY;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (res_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      last_q     <= '0;
      letter_q   <= '0;
      prev_rec_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      last_q     <= last_d;
      letter_q   <= letter_d;
      prev_rec_q <= prev_rec_d;
    end
  end

  // Variable store, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumVars; i++) vars_q[i] <= '0;
    end else if (var_we) begin
      vars_q[letter_q] <= var_wd;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_i.valid) begin
      op_q   <= cmd_i.func;
      val_q  <= cmd_i.operand_value;
      vidx_q <= cmd_i.var_index;
    end
    a_q <= a_d;  b_q <= b_d;  empty_q <= empty_d;  neg_q <= neg_d;
    status_q <= status_d;  show_q <= show_d;  shown_q <= shown_d;
    acc_q <= acc_d;  prod_q <= prod_d;  num_q <= num_d;  quo_q <= quo_d;
    rem_q <= rem_d;  dvs_q <= dvs_d;  step_q <= step_d;
  end

  assign cmd_i.ready       = (state_q == S_IDLE);
  assign res_o.valid       = (state_q == S_OUT);
  assign res_o.status      = status_q;
  assign res_o.show_valid  = show_q;
  assign res_o.shown_value = shown_q;
  assign res_o.depth_now   = 8'(count_q);

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH)) else $error("stack count past depth");
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && cmd_i.ready |=> !cmd_i.ready && !res_o.valid)
    else $error("command overlap");
  a_no_show_on_zdiv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.status == ST_ZERO_DIV |-> !res_o.show_valid)
    else $error("show on zero divisor");
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.ready && res_o.valid)) else $error("ready while result pending");

endmodule

@@ sim/rpn_test_if.sv @@
// ----------------------------------------------------------------------------
// RPN calculator test channels
// Testbench copies of the channel interfaces are not needed; the design's own
// interfaces are used. This file holds the stall pattern helper only.
// ----------------------------------------------------------------------------
package rpn_test_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  // Receiver stall pattern: stall in cycles where the pattern bit is set
  function automatic logic stall_pattern(input int unsigned cyc,
                                         input logic [15:0] pat);
    return pat[cyc % 16];
  endfunction
endpackage

@@ sim/rpn_stack_calculator_unit_test.sv @@
// ----------------------------------------------------------------------------
// RPN stack calculator testbench
// Drives command words with bursty gaps, stalls the result channel, predicts
// each result from a behavioral model of the calculator and checks in order.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_unit_test;
  import rpn_pkg::*;
  import rpn_test_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 128;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic [2:0]  status;
    logic        show_valid;
    logic [63:0] shown_value;
    logic [7:0]  depth_now;
  } result_t;

  // Scoreboard: behavioral calculator plus queue of expected result words
  class calc_scoreboard;
    logic [63:0] stk [Depth];
    int unsigned count;
    logic [63:0] vars [NumVars];
    logic [63:0] last_val;
    logic [4:0]  prev_letter;
    logic        prev_recall;
    result_t     pending [$];
    int unsigned errors, checked, shows;
    int unsigned func_seen [16];

    function new();
      count = 0; last_val = '0; prev_letter = '0; prev_recall = 1'b0;
      foreach (vars[i]) vars[i] = '0;
      foreach (stk[i]) stk[i] = '0;
      errors = 0; checked = 0; shows = 0;
    endfunction

    function logic [63:0] pop_word(ref logic empty);
      if (count == 0) begin
        empty = 1'b1;
        return '0;
      end
      count--;
      return stk[count];
    endfunction

    function logic push_word(logic [63:0] v);
      if (count >= Depth) return 1'b0;
      stk[count] = v;
      count++;
      return 1'b1;
    endfunction

    function logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = mag(a) * mag(b);
      return sat_signed(a[63] ^ b[63], |p[127:96], p[95:32]);
    endfunction

    function logic [63:0] fx_div(logic [63:0] a, logic [63:0] b);
      logic [127:0] q;
      q = {32'd0, mag(a), 32'd0} / {64'd0, mag(b)};
      return sat_signed(a[63] ^ b[63], |q[127:64], q[63:0]);
    endfunction

    function logic [63:0] fx_rem(logic [63:0] a, logic [63:0] b);
      logic [63:0] r;
      r = mag(a) % mag(b);
      return a[63] ? 64'd0 - r : r;
    endfunction

    // Apply one accepted command and queue its result
    function void note_command(logic [3:0] f, logic [63:0] v, logic [4:0] vi);
      result_t r;
      logic empty, rec_now;
      logic [63:0] a, b, t;
      r = '0; empty = 1'b0; rec_now = 1'b0;
      func_seen[f]++;
      case (f)
        FUNC_PUSH: if (!push_word(v)) r.status = ST_FULL;
        FUNC_ADD, FUNC_SUB, FUNC_MUL: begin
          b = pop_word(empty);
          a = pop_word(empty);
          t = (f == FUNC_ADD) ? q_add(a, b) : (f == FUNC_SUB) ? q_sub(a, b) : fx_mul(a, b);
          void'(push_word(t));
          if (empty) r.status = ST_EMPTY;
        end
        FUNC_DIV, FUNC_REM: begin
          b = pop_word(empty);
          if (b == 0) begin
            r.status = empty ? ST_EMPTY : ST_ZERO_DIV;
          end else begin
            a = pop_word(empty);
            void'(push_word(f == FUNC_DIV ? fx_div(a, b) : fx_rem(a, b)));
            if (empty) r.status = ST_EMPTY;
          end
        end
        FUNC_TOP: begin
          if (count == 0) begin
            t = '0;
            r.status = ST_EMPTY;
          end else t = stk[count-1];
          last_val = t; r.show_valid = 1'b1; r.shown_value = t;
        end
        FUNC_DUP: begin
          if (count == 0) r.status = ST_EMPTY;
          else if (count >= Depth) r.status = ST_FULL;
          else void'(push_word(stk[count-1]));
        end
        FUNC_SWAP: begin
          if (count < 2) r.status = ST_FEW_SWAP;
          else begin
            t = stk[count-1]; stk[count-1] = stk[count-2]; stk[count-2] = t;
          end
        end
        FUNC_CLEAR: count = 0;
        FUNC_ASSIGN: begin
          void'(pop_word(empty));
          if (!prev_recall || prev_letter >= NumVars) r.status = ST_BAD_VAR;
          else begin
            vars[prev_letter] = pop_word(empty);
            if (empty) r.status = ST_EMPTY;
          end
        end
        FUNC_RECALL: begin
          if (vi >= NumVars) r.status = ST_BAD_VAR;
          else begin
            if (!push_word(vars[vi])) r.status = ST_FULL;
            prev_letter = vi; rec_now = 1'b1;
          end
        end
        FUNC_LAST: if (!push_word(last_val)) r.status = ST_FULL;
        FUNC_EOL: begin
          t = pop_word(empty);
          if (empty) r.status = ST_EMPTY;
          last_val = t; r.show_valid = 1'b1; r.shown_value = t;
        end
        default: ;
      endcase
      prev_recall = rec_now;
      r.depth_now = count[7:0];
      pending.push_back(r);
    endfunction

    // Compare one accepted result word with the oldest expectation
    function void check_result(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got.show_valid) shows++;
      if (got.status !== exp_r.status) begin
        $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
      end
      if (got.show_valid !== exp_r.show_valid) begin
        $error("show_valid exp %0d got %0d", exp_r.show_valid, got.show_valid); errors++;
      end
      if (got.shown_value !== exp_r.shown_value) begin
        $error("shown_value exp %h got %h", exp_r.shown_value, got.shown_value); errors++;
      end
      if (got.depth_now !== exp_r.depth_now) begin
        $error("depth_now exp %0d got %0d", exp_r.depth_now, got.depth_now); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  rpn_cmd_if cmd_ch ();
  rpn_res_if res_ch ();

  rpn_stack_calculator_unit #(.STACK_DEPTH(Depth)) dut (
    .clk_i (clk_i), .rst_ni (rst_ni), .cmd_i (cmd_ch.sink), .res_o (res_ch.source)
  );

  calc_scoreboard calc_sb;
  logic           long_hold;
  logic [15:0]    stall_pat;
  int unsigned    idle_cycles, cyc;
  bit             stim_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Monitor: note accepted commands, check accepted results, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cyc <= cyc + 1;
      if (cmd_ch.valid && cmd_ch.ready)
        calc_sb.note_command(cmd_ch.func, cmd_ch.operand_value, cmd_ch.var_index);
      if (res_ch.valid && res_ch.ready)
        calc_sb.check_result({res_ch.status, res_ch.show_valid,
                              res_ch.shown_value, res_ch.depth_now});
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (stim_done && calc_sb.pending.size() == 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver: own stall pattern, occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= !long_hold && !stall_pattern(cyc, stall_pat);
    end
  end

  // Offer one command word and hold it until accepted
  task automatic send_word(logic [3:0] f, logic [63:0] v, logic [4:0] vi);
    cmd_ch.valid <= 1'b1;
    cmd_ch.func <= f;
    cmd_ch.operand_value <= v;
    cmd_ch.var_index <= vi;
    do @(posedge clk_i); while (!(cmd_ch.valid && cmd_ch.ready));
  endtask

  task automatic idle_gap(int unsigned n);
    cmd_ch.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (calc_sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 7))
      0: return QMax;
      1: return QMin;
      2: return 64'd0;
      3: return {32'($urandom_range(0, 20)) - 32'd10, 32'd0};
      4: return {{32{1'b0}}, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic random_word();
    logic [3:0] f;
    logic [4:0] vi;
    f = 4'($urandom_range(0, 13));
    if ($urandom_range(0, 49) == 0) f = 4'($urandom_range(14, 15));
    if ($urandom_range(0, 2) == 0) f = FUNC_PUSH;
    vi = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31)) : 5'($urandom_range(0, 25));
    // well-formed recall/assign pair now and then
    if ($urandom_range(0, 9) == 0) begin
      send_word(FUNC_PUSH, rand_value(), '0);
      send_word(FUNC_RECALL, '0, 5'($urandom_range(0, 25)));
      f = FUNC_ASSIGN;
    end
    send_word(f, rand_value(), vi);
  endtask

  initial begin
    int unsigned burst;
    int unsigned kinds;
    calc_sb = new();
    stim_done = 1'b0; long_hold = 1'b0; stall_pat = '0; cyc = 0; idle_cycles = 0;
    cmd_ch.valid = 1'b0; cmd_ch.func = FUNC_PUSH; cmd_ch.operand_value = '0;
    cmd_ch.var_index = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-stack cases, extremes, saturation, zero divisor
    send_word(FUNC_EOL, '0, '0);
    send_word(FUNC_TOP, '0, '0);
    send_word(FUNC_ADD, '0, '0);
    send_word(FUNC_DUP, '0, '0);
    send_word(FUNC_SWAP, '0, '0);
    send_word(FUNC_ASSIGN, '0, '0);
    send_word(FUNC_PUSH, QMax, '0);
    send_word(FUNC_PUSH, QMax, '0);
    send_word(FUNC_ADD, '0, '0);
    send_word(FUNC_PUSH, QMin, '0);
    send_word(FUNC_MUL, '0, '0);
    send_word(FUNC_PUSH, 64'h0000_0001_8000_0000, '0);
    send_word(FUNC_PUSH, '0, '0);
    send_word(FUNC_DIV, '0, '0);
    send_word(FUNC_PUSH, -64'sd7, '0);
    send_word(FUNC_REM, '0, '0);
    send_word(FUNC_RECALL, '0, 5'd25);
    send_word(FUNC_ASSIGN, '0, '0);
    send_word(FUNC_RECALL, '0, 5'd31);
    send_word(FUNC_LAST, '0, '0);
    send_word(FUNC_SWAP, '0, '0);
    send_word(FUNC_SUB, '0, '0);
    send_word(4'd15, '1, '1);
    send_word(FUNC_CLEAR, '0, '0);

    // Fill past full with the receiver held off, then drain
    long_hold <= 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        long_hold <= 1'b0;
      end
    join_none
    for (int i = 0; i < Depth + 2; i++) send_word(FUNC_PUSH, rand_value(), '0);
    send_word(FUNC_DUP, '0, '0);
    send_word(FUNC_RECALL, '0, 5'd3);
    send_word(FUNC_LAST, '0, '0);
    wait_drained();
    send_word(FUNC_CLEAR, '0, '0);

    // Random bursts with gaps
    for (int n = 0; n < 650; n += burst) begin
      burst = $urandom_range(1, 20);
      stall_pat = (n % 200 < 40) ? 16'h0 : (16'($urandom()) & 16'h7FFF);
      for (int k = 0; k < burst; k++) random_word();
      if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 12));
      if (n > 400 && n < 430) wait_drained();
    end
    wait_drained();
    stim_done = 1'b1;
    repeat (120) @(posedge clk_i);
    kinds = 0;
    for (int f = 0; f < 14; f++) if (calc_sb.func_seen[f] != 0) kinds++;
    $display("checked %0d result words, %0d with a shown value, %0d of 14 commands driven",
             calc_sb.checked, calc_sb.shows, kinds);
    if (calc_sb.errors == 0 && calc_sb.pending.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
